### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when en holds, expr must hold.
`define ASSERT_IMPL(label, en, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (expr)) \
        else $error(msg);

// Next-cycle implication: when en holds, expr must hold on the next cycle.
`define ASSERT_NEXT(label, en, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (expr)) \
        else $error(msg);

`endif

### rtl/dhmc_pkg.sv
// ---------------------------------------------------------------------------
// dhmc_pkg
// Types and constants shared by the dryer heater mode controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhmc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_HEATING = 3'd1,
        MODE_HOLDING = 3'd2,
        MODE_COOLING = 3'd3,
        MODE_MANUAL  = 3'd4,
        MODE_SAFETY  = 3'd5
    } mode_t;

    // Command codes
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_PRESET     = 3'd1;
    localparam logic [2:0] REQ_RESET      = 3'd2;
    localparam logic [2:0] REQ_MAN_HEATER = 3'd3;
    localparam logic [2:0] REQ_MAN_FAN    = 3'd4;

    // Register map (word index)
    localparam int          ADDR_W        = 4;
    localparam logic [1:0]  REG_TRIP      = 2'd0;
    localparam logic [1:0]  REG_RELEASE   = 2'd1;
    localparam logic [1:0]  REG_COOLED    = 2'd2;

    localparam int          TEMP_CFG_W    = 11;
    localparam logic [10:0] TRIP_RST      = 11'd800;
    localparam logic [10:0] RELEASE_RST   = 11'd750;
    localparam logic [10:0] COOLED_RST    = 11'd300;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [11:0] temperature;
        logic               time_left;
        logic [7:0]         preset_target;
        logic [31:0]        preset_duration;
        logic               switch_on;
    } req_t;

    typedef struct packed {
        mode_t       mode;
        logic        heater_drive;
        logic        fan_drive;
        logic        timer_load;
        logic [31:0] timer_value;
    } rsp_t;

    typedef struct packed {
        logic [TEMP_CFG_W-1:0] safety_trip_temp;
        logic [TEMP_CFG_W-1:0] safety_release_temp;
        logic [TEMP_CFG_W-1:0] cooled_temp;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/dhmc_regs.sv
// ---------------------------------------------------------------------------
// dhmc_regs
// APB register file holding the three temperature thresholds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhmc_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dhmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output dhmc_pkg::cfg_t                  cfg
);

    logic [dhmc_pkg::TEMP_CFG_W-1:0] trip_reg;
    logic [dhmc_pkg::TEMP_CFG_W-1:0] release_reg;
    logic [dhmc_pkg::TEMP_CFG_W-1:0] cooled_reg;
    logic [1:0]                      index;
    logic                            wr_en;

    assign index = paddr[3:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trip_reg    <= dhmc_pkg::TRIP_RST;
            release_reg <= dhmc_pkg::RELEASE_RST;
            cooled_reg  <= dhmc_pkg::COOLED_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                dhmc_pkg::REG_TRIP:    trip_reg    <= pwdata[dhmc_pkg::TEMP_CFG_W-1:0];
                dhmc_pkg::REG_RELEASE: release_reg <= pwdata[dhmc_pkg::TEMP_CFG_W-1:0];
                dhmc_pkg::REG_COOLED:  cooled_reg  <= pwdata[dhmc_pkg::TEMP_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            dhmc_pkg::REG_TRIP:    prdata = {21'd0, trip_reg};
            dhmc_pkg::REG_RELEASE: prdata = {21'd0, release_reg};
            dhmc_pkg::REG_COOLED:  prdata = {21'd0, cooled_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.safety_trip_temp    = trip_reg;
    assign cfg.safety_release_temp = release_reg;
    assign cfg.cooled_temp         = cooled_reg;

endmodule

`default_nettype wire

### rtl/dhmc_ctrl.sv
// ---------------------------------------------------------------------------
// dhmc_ctrl
// Mode state and relay rules; computes one result per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhmc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire dhmc_pkg::req_t req,
    input  wire dhmc_pkg::cfg_t cfg,
    output dhmc_pkg::rsp_t      rsp
);

    dhmc_pkg::mode_t mode_reg, mode_next;
    logic [7:0]      target_reg, target_next;
    logic            heater_reg, heater_next;
    logic            fan_reg, fan_next;
    logic            load;
    logic [31:0]     tval;

    logic signed [12:0] temp_ext;
    logic signed [12:0] trip_ext;
    logic signed [12:0] release_ext;
    logic signed [12:0] cooled_ext;
    logic signed [12:0] tgt_ext;
    logic signed [12:0] ptgt_ext;

    // Whole degrees to tenths: x*8 + x*2
    function automatic logic [11:0] times10(input logic [7:0] x);
        logic [11:0] w;
        begin
            w = {4'd0, x};
            times10 = (w << 3) + (w << 1);
        end
    endfunction

    assign temp_ext    = {req.temperature[11], req.temperature};
    assign trip_ext    = {2'b00, cfg.safety_trip_temp};
    assign release_ext = {2'b00, cfg.safety_release_temp};
    assign cooled_ext  = {2'b00, cfg.cooled_temp};
    assign tgt_ext     = {1'b0, times10(target_reg)};
    assign ptgt_ext    = {1'b0, times10(req.preset_target)};

    always_comb
    begin
        mode_next   = mode_reg;
        target_next = target_reg;
        heater_next = heater_reg;
        fan_next    = fan_reg;
        load        = 1'b0;
        tval        = 32'd0;

        unique case (req.req_type)
            dhmc_pkg::REQ_TICK:
            begin
                // Safety trip wins over the mode rules, unless already in safety
                if (temp_ext >= trip_ext && mode_reg != dhmc_pkg::MODE_SAFETY)
                begin
                    heater_next = 1'b0;
                    fan_next    = 1'b1;
                    mode_next   = dhmc_pkg::MODE_SAFETY;
                end
                else
                begin
                    unique case (mode_reg)
                        dhmc_pkg::MODE_HEATING:
                        begin
                            if (!req.time_left)
                            begin
                                heater_next = 1'b0;
                                mode_next   = dhmc_pkg::MODE_COOLING;
                            end
                            else if (temp_ext >= tgt_ext)
                            begin
                                heater_next = 1'b0;
                                mode_next   = dhmc_pkg::MODE_HOLDING;
                            end
                        end
                        dhmc_pkg::MODE_HOLDING:
                        begin
                            if (!req.time_left)
                            begin
                                heater_next = 1'b0;
                                mode_next   = dhmc_pkg::MODE_COOLING;
                            end
                            else if (temp_ext < tgt_ext)
                            begin
                                heater_next = 1'b1;
                                mode_next   = dhmc_pkg::MODE_HEATING;
                            end
                        end
                        dhmc_pkg::MODE_COOLING:
                        begin
                            if (temp_ext < cooled_ext)
                            begin
                                fan_next  = 1'b0;
                                mode_next = dhmc_pkg::MODE_IDLE;
                            end
                        end
                        dhmc_pkg::MODE_SAFETY:
                        begin
                            if (temp_ext < release_ext)
                            begin
                                if (target_reg != 8'd0 && req.time_left)
                                begin
                                    mode_next = dhmc_pkg::MODE_COOLING;
                                end
                                else
                                begin
                                    fan_next  = 1'b0;
                                    mode_next = dhmc_pkg::MODE_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dhmc_pkg::REQ_PRESET:
            begin
                target_next = req.preset_target;
                fan_next    = 1'b1;
                if (temp_ext >= ptgt_ext)
                begin
                    heater_next = 1'b0;
                    mode_next   = dhmc_pkg::MODE_HOLDING;
                end
                else
                begin
                    heater_next = 1'b1;
                    mode_next   = dhmc_pkg::MODE_HEATING;
                end
                load = 1'b1;
                tval = req.preset_duration;
            end
            dhmc_pkg::REQ_RESET:
            begin
                target_next = 8'd0;
                heater_next = 1'b0;
                fan_next    = 1'b1;
                mode_next   = dhmc_pkg::MODE_COOLING;
                load        = 1'b1;
            end
            dhmc_pkg::REQ_MAN_HEATER:
            begin
                heater_next = req.switch_on;
                if (req.switch_on)
                begin
                    fan_next = 1'b1;
                end
                mode_next = dhmc_pkg::MODE_MANUAL;
            end
            dhmc_pkg::REQ_MAN_FAN:
            begin
                fan_next  = req.switch_on;
                mode_next = dhmc_pkg::MODE_MANUAL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= dhmc_pkg::MODE_IDLE;
            target_reg <= 8'd0;
            heater_reg <= 1'b0;
            fan_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            heater_reg <= heater_next;
            fan_reg    <= fan_next;
        end
    end

    assign rsp.mode         = mode_next;
    assign rsp.heater_drive = heater_next;
    assign rsp.fan_drive    = fan_next;
    assign rsp.timer_load   = load;
    assign rsp.timer_value  = tval;

endmodule

`default_nettype wire

### rtl/dryer_heater_mode_controller_top.sv
// ---------------------------------------------------------------------------
// dryer_heater_mode_controller_top
// Heater and fan mode controller with request input and result output.
// ---------------------------------------------------------------------------
// Takes one request per cycle unless the result path stalls, and returns one
// result per request, in order. A request is captured in an input register,
// evaluated against the mode state in a single pass and written to the
// result register, which offers it; the mode state is updated in the same
// edge, so the next request sees it at once. The input register lets a new
// request in while a finished result waits. Thresholds are set over APB and
// should be changed only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dryer_heater_mode_controller_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire dhmc_pkg::req_t              req_data,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output dhmc_pkg::rsp_t                   rsp_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dhmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic           in_valid_reg;
    dhmc_pkg::req_t in_data_reg;
    logic           out_valid_reg;
    dhmc_pkg::rsp_t out_data_reg;
    logic           advance;
    dhmc_pkg::cfg_t cfg;
    dhmc_pkg::rsp_t rsp_next;

    assign pready    = 1'b1;
    // Move the held request into the result register when that slot is free
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    dhmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dhmc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (in_data_reg),
        .cfg     (cfg),
        .rsp     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req_data;
        end
        if (advance)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/dhmc_checker.sv
// ---------------------------------------------------------------------------
// dhmc_checker
// Port-level checks for the mode controller, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dhmc_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rsp_valid,
    input  wire logic           rsp_ready,
    input  wire dhmc_pkg::rsp_t rsp_data
);

    // Hold a stalled result
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

    // Drop the timer value unless a load is signaled
    `ASSERT_IMPL(a_tval_zero, rsp_valid && !rsp_data.timer_load, rsp_data.timer_value == 32'd0, "timer value without load")

    // Heater runs only in heating or manual mode
    `ASSERT_IMPL(a_heater_mode, rsp_valid && rsp_data.heater_drive, rsp_data.mode == dhmc_pkg::MODE_HEATING || rsp_data.mode == dhmc_pkg::MODE_MANUAL, "heater on outside heating or manual")

    // Safety keeps heater off and fan on
    `ASSERT_IMPL(a_safety_relays, rsp_valid && rsp_data.mode == dhmc_pkg::MODE_SAFETY, !rsp_data.heater_drive && rsp_data.fan_drive, "bad relay drive in safety")

endmodule

bind dryer_heater_mode_controller_top dhmc_checker u_dhmc_checker (.*);

`default_nettype wire

### test/dryer_heater_mode_controller_top_tb.sv
// ---------------------------------------------------------------------------
// dryer_heater_mode_controller_top_tb
// Self-checking bench for the heater and fan mode controller: a queue-fed
// driver offers requests, a clocked monitor predicts each result on accept
// and compares it field by field, and threshold registers are rewritten
// over APB between phases of directed and random traffic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dryer_heater_mode_controller_top_tb;

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         HOLD_CYCLES = 60;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    dhmc_pkg::req_t              req_data  = '0;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    dhmc_pkg::rsp_t              rsp_data;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [dhmc_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    dryer_heater_mode_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Controller shadow state and thresholds
    dhmc_pkg::mode_t mode_now   = dhmc_pkg::MODE_IDLE;
    logic [7:0]      target_now = 8'd0;
    logic            heater_now = 1'b0;
    logic            fan_now    = 1'b0;
    int              lim_trip    = 800;
    int              lim_release = 750;
    int              lim_cooled  = 300;

    dhmc_pkg::req_t pending_requests[$];
    dhmc_pkg::rsp_t due_results[$];
    dhmc_pkg::rsp_t want_rsp;

    bit req_took;
    bit rsp_took;
    bit req_idle_on = 1'b1;
    bit rsp_idle_on = 1'b1;
    int req_gap;
    int rsp_gap;
    int rsp_hold;
    int results_seen;
    int quiet_cycles;
    int mismatches;
    int last_target = 50;

    function automatic dhmc_pkg::rsp_t predict_drives(input dhmc_pkg::req_t r);
        dhmc_pkg::rsp_t o;
        int   t;
        int   goal;
        t    = $signed(r.temperature);
        goal = int'(target_now) * 10;
        o    = '0;
        case (r.req_type)
            dhmc_pkg::REQ_TICK:
            begin
                if (t >= lim_trip && mode_now != dhmc_pkg::MODE_SAFETY)
                begin
                    heater_now = 1'b0;
                    fan_now    = 1'b1;
                    mode_now   = dhmc_pkg::MODE_SAFETY;
                end
                else
                begin
                    case (mode_now)
                        dhmc_pkg::MODE_HEATING, dhmc_pkg::MODE_HOLDING:
                        begin
                            if (!r.time_left)
                            begin
                                heater_now = 1'b0;
                                mode_now   = dhmc_pkg::MODE_COOLING;
                            end
                            else if (mode_now == dhmc_pkg::MODE_HEATING && t >= goal)
                            begin
                                heater_now = 1'b0;
                                mode_now   = dhmc_pkg::MODE_HOLDING;
                            end
                            else if (mode_now == dhmc_pkg::MODE_HOLDING && t < goal)
                            begin
                                heater_now = 1'b1;
                                mode_now   = dhmc_pkg::MODE_HEATING;
                            end
                        end
                        dhmc_pkg::MODE_COOLING:
                        begin
                            if (t < lim_cooled)
                            begin
                                fan_now  = 1'b0;
                                mode_now = dhmc_pkg::MODE_IDLE;
                            end
                        end
                        dhmc_pkg::MODE_SAFETY:
                        begin
                            if (t < lim_release)
                            begin
                                if (target_now != 8'd0 && r.time_left)
                                    mode_now = dhmc_pkg::MODE_COOLING;
                                else
                                begin
                                    fan_now  = 1'b0;
                                    mode_now = dhmc_pkg::MODE_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dhmc_pkg::REQ_PRESET:
            begin
                target_now = r.preset_target;
                fan_now    = 1'b1;
                if (t >= int'(r.preset_target) * 10)
                begin
                    heater_now = 1'b0;
                    mode_now   = dhmc_pkg::MODE_HOLDING;
                end
                else
                begin
                    heater_now = 1'b1;
                    mode_now   = dhmc_pkg::MODE_HEATING;
                end
                o.timer_load  = 1'b1;
                o.timer_value = r.preset_duration;
            end
            dhmc_pkg::REQ_RESET:
            begin
                target_now    = 8'd0;
                heater_now    = 1'b0;
                fan_now       = 1'b1;
                mode_now      = dhmc_pkg::MODE_COOLING;
                o.timer_load  = 1'b1;
            end
            dhmc_pkg::REQ_MAN_HEATER:
            begin
                heater_now = r.switch_on;
                if (r.switch_on)
                    fan_now = 1'b1;
                mode_now = dhmc_pkg::MODE_MANUAL;
            end
            dhmc_pkg::REQ_MAN_FAN:
            begin
                fan_now  = r.switch_on;
                mode_now = dhmc_pkg::MODE_MANUAL;
            end
            default: ;
        endcase
        o.mode         = mode_now;
        o.heater_drive = heater_now;
        o.fan_drive    = fan_now;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: sample both handshakes, check results, predict on accept
    always @(posedge clk)
    begin
        req_took = req_valid && req_ready;
        rsp_took = rsp_valid && rsp_ready;
        if (rsp_took)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
                mismatches++;
            end
            else
            begin
                want_rsp = due_results.pop_front();
                check_field("mode", 32'(want_rsp.mode), 32'(rsp_data.mode));
                check_field("heater_drive", 32'(want_rsp.heater_drive),
                            32'(rsp_data.heater_drive));
                check_field("fan_drive", 32'(want_rsp.fan_drive), 32'(rsp_data.fan_drive));
                check_field("timer_load", 32'(want_rsp.timer_load),
                            32'(rsp_data.timer_load));
                check_field("timer_value", want_rsp.timer_value, rsp_data.timer_value);
            end
        end
        if (req_took)
            due_results.push_back(predict_drives(req_data));
        if (req_took || rsp_took)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Driver: hold each request until taken, then idle a drawn gap
    always @(negedge clk)
    begin
        if (!req_valid || req_took)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                req_data  <= pending_requests.pop_front();
                req_valid <= 1'b1;
                req_gap    = req_idle_on ? $urandom_range(0, 5) : 0;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: stall a drawn number of cycles per result, plus long hold-offs
    always @(negedge clk)
    begin
        if (rsp_took)
        begin
            rsp_gap = rsp_idle_on ? $urandom_range(0, 5) : 0;
            if (results_seen == 100 || results_seen == 350)
                rsp_hold = HOLD_CYCLES;
        end
        if (rsp_hold > 0)
        begin
            rsp_hold--;
            rsp_ready <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic apb_write(input logic [1:0] idx, input logic [10:0] val);
        logic [31:0] wd;
        wd       = $urandom;
        wd[10:0] = val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            dhmc_pkg::REG_TRIP:    lim_trip    = val;
            dhmc_pkg::REG_RELEASE: lim_release = val;
            dhmc_pkg::REG_COOLED:  lim_cooled  = val;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic [10:0] trip, input logic [10:0] rel,
                              input logic [10:0] cooled);
        apb_write(dhmc_pkg::REG_TRIP, trip);
        apb_write(dhmc_pkg::REG_RELEASE, rel);
        apb_write(dhmc_pkg::REG_COOLED, cooled);
    endtask

    task automatic add_req(input logic [2:0] kind, input int temp, input logic tl,
                           input logic [7:0] tgt, input logic [31:0] dur, input logic sw);
        dhmc_pkg::req_t r;
        r.req_type        = kind;
        r.temperature     = temp[11:0];
        r.time_left       = tl;
        r.preset_target   = tgt;
        r.preset_duration = dur;
        r.switch_on       = sw;
        pending_requests.push_back(r);
    endtask

    task automatic add_random_reqs(input int count);
        logic [2:0] kind;
        logic [7:0] tgt;
        int         tv;
        int         k;
        repeat (count)
        begin
            k = $urandom_range(0, 99);
            if (k < 50)
                kind = dhmc_pkg::REQ_TICK;
            else if (k < 65)
                kind = dhmc_pkg::REQ_PRESET;
            else if (k < 73)
                kind = dhmc_pkg::REQ_RESET;
            else if (k < 83)
                kind = dhmc_pkg::REQ_MAN_HEATER;
            else if (k < 94)
                kind = dhmc_pkg::REQ_MAN_FAN;
            else
                kind = 3'($urandom_range(5, 7));
            tgt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(20, 110));
            if (kind == dhmc_pkg::REQ_PRESET)
                last_target = tgt;
            // aim most temperatures at the thresholds that decide mode changes
            case ($urandom_range(0, 9))
                0:       tv = $urandom_range(0, 4095);
                1:       tv = lim_trip + int'($urandom_range(0, 6)) - 3;
                2:       tv = lim_release + int'($urandom_range(0, 6)) - 3;
                3:       tv = lim_cooled + int'($urandom_range(0, 6)) - 3;
                4, 5:    tv = last_target * 10 + int'($urandom_range(0, 6)) - 3;
                default: tv = int'($urandom_range(0, 1650)) - 400;
            endcase
            add_req(kind, tv, ($urandom_range(0, 99) < 85), tgt, $urandom,
                    1'($urandom));
        end
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pending_requests.size() != 0 || req_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit req_idle, input bit rsp_idle);
        req_idle_on = req_idle;
        rsp_idle_on = rsp_idle;
        add_random_reqs(count);
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_limits(11'd800, 11'd750, 11'd300);

        // Walk the mode rules: heat, hold, cool, safety, manual, unused codes
        add_req(dhmc_pkg::REQ_TICK, 0, 1'b0, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_PRESET, -2048, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_PRESET, 2047, 1'b1, 8'd255, 32'hFFFF_FFFF, 1'b1);
        add_req(dhmc_pkg::REQ_PRESET, 200, 1'b1, 8'd50, 32'h5A5A_A5A5, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 499, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 500, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 499, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 600, 1'b0, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 300, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 299, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 800, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 2047, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 750, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 749, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 900, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_TICK, 100, 1'b0, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_PRESET, 300, 1'b1, 8'd30, 32'h0000_0001, 1'b0);
        add_req(dhmc_pkg::REQ_RESET, 300, 1'b1, 8'd77, 32'hDEAD_BEEF, 1'b1);
        add_req(dhmc_pkg::REQ_MAN_HEATER, 100, 1'b1, 8'd0, 32'd0, 1'b1);
        add_req(dhmc_pkg::REQ_MAN_HEATER, 100, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_MAN_FAN, 100, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(dhmc_pkg::REQ_MAN_FAN, 100, 1'b1, 8'd0, 32'd0, 1'b1);
        add_req(dhmc_pkg::REQ_TICK, 850, 1'b1, 8'd0, 32'd0, 1'b0);
        add_req(3'd5, -1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        add_req(3'd7, 700, 1'b0, 8'd0, 32'h1234_5678, 1'b0);
        drain();

        run_phase(150, 1'b1, 1'b1);

        // Everything trips; safety is left only below zero
        set_limits(11'd0, 11'd0, 11'd0);
        run_phase(80, 1'b1, 1'b0);

        set_limits(11'd2047, 11'd2000, 11'd2000);
        run_phase(100, 1'b0, 1'b1);

        set_limits(11'd300, 11'd200, 11'd100);
        apb_write(REG_SPARE, 11'd5);
        run_phase(150, 1'b1, 1'b1);

        set_limits(11'd800, 11'd750, 11'd300);
        run_phase(120, 1'b0, 1'b0);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### dryer_heater_mode_controller_top.f
+incdir+rtl
rtl/dhmc_pkg.sv
rtl/dhmc_regs.sv
rtl/dhmc_ctrl.sv
rtl/dryer_heater_mode_controller_top.sv
rtl/dhmc_checker.sv
test/dryer_heater_mode_controller_top_tb.sv
